### rtl/ring_queue_with_slot_removal_core_macros.svh
// Assertion macros shared by the ring queue RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef RING_QUEUE_WITH_SLOT_REMOVAL_CORE_MACROS_SVH
`define RING_QUEUE_WITH_SLOT_REMOVAL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RQSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RQSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rqsr_pkg.sv
// Package for the ring queue with slot removal: default sizes, request and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rqsr_pkg;

  localparam int DepthDef     = 16;
  localparam int DataWidthDef = 32;

  typedef enum logic [1:0] {
    REQ_ENQ = 2'd0,
    REQ_DEQ = 2'd1,
    REQ_CLR = 2'd2,
    REQ_REM = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOSLOT = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // Request transaction taken this cycle.
    logic deq_fin;    // RAM read data for a dequeue is available.
    logic shift_run;  // One step of the removal shift.
    logic load_out;   // Capture the result into the output register.
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic deq_wait;    // Offered request is a dequeue on a non-empty queue.
    logic shift_wait;  // Offered request is a removal that must move entries.
    logic shift_last;  // The current shift step writes the last entry.
  } stat_t;

endpackage

`default_nettype wire

### rtl/rqsr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rqsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/rqsr_ctrl.sv
// Controller state machine for the ring queue: handshakes and sequencing.
// Depends on rqsr_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ring_queue_with_slot_removal_core_macros.svh"

module rqsr_ctrl
  import rqsr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output      logic  in_ready_o,
  output      logic  out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output      cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DEQ   = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load_out;

  // A new request is taken only when the result register is free or drains now.
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign load_out = (accept && !stat_i.deq_wait && !stat_i.shift_wait)
                 || (state_q == S_DEQ)
                 || ((state_q == S_SHIFT) && stat_i.shift_last);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && stat_i.deq_wait) begin
          state_d = S_DEQ;
        end else if (accept && stat_i.shift_wait) begin
          state_d = S_SHIFT;
        end
      end
      S_DEQ: begin
        state_d = S_IDLE;
      end
      S_SHIFT: begin
        if (stat_i.shift_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cmd_o.accept    = accept;
  assign cmd_o.deq_fin   = (state_q == S_DEQ);
  assign cmd_o.shift_run = (state_q == S_SHIFT);
  assign cmd_o.load_out  = load_out;

  // The result register must be free while a dequeue or a removal shift is in progress.
  `RQSR_ASSERT_IMPL(a_busy_out_free, clk_i, rst_ni, (state_q == S_DEQ) || (state_q == S_SHIFT), !out_valid_q, "result register occupied during a long request")
  `RQSR_ASSERT_NEXT(a_deq_one_cycle, clk_i, rst_ni, state_q == S_DEQ, (state_q == S_IDLE) && out_valid_q, "dequeue did not complete after its read")
  `RQSR_ASSERT_NEXT(a_fast_result, clk_i, rst_ni, accept && !stat_i.deq_wait && !stat_i.shift_wait, out_valid_q && (state_q == S_IDLE), "single-cycle request gave no result")

endmodule

`default_nettype wire

### rtl/rqsr_dpath.sv
// Datapath for the ring queue: pointers, count, entry RAM, shift pointers
// and the result register. Depends on rqsr_pkg, rqsr_ram and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ring_queue_with_slot_removal_core_macros.svh"

module rqsr_dpath
  import rqsr_pkg::*;
#(
  parameter int DEPTH      = DepthDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cmd_t                           cmd_i,
  output      stat_t                          stat_o,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic [DATA_WIDTH-1:0]          data_in_i,
  input  wire logic [$clog2(DEPTH)-1:0]       slot_i,
  output      logic [DATA_WIDTH-1:0]          data_out_o,
  output      logic [1:0]                     status_o,
  output      logic [$clog2(DEPTH+1)-1:0]     count_out_o
);

  localparam int SlotW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int OffW  = SlotW + 1;

  function automatic logic [SlotW-1:0] wrap_next(input logic [SlotW-1:0] p);
    wrap_next = (p == SlotW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SlotW-1:0] wrap_prev(input logic [SlotW-1:0] p);
    wrap_prev = (p == '0) ? SlotW'(DEPTH - 1) : p - 1'b1;
  endfunction

  logic [SlotW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [SlotW-1:0]      rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [SlotW-1:0]      left_q, left_d;
  logic                  wr_pend_q, wr_pend_d;
  logic [DATA_WIDTH-1:0] data_out_q;
  status_e               status_q;
  logic [CntW-1:0]       cnt_out_q;

  req_e                  req;
  logic                  full, empty, slot_ok, live;
  logic [OffW-1:0]       slot_x, head_x, offset, steps;
  logic [DATA_WIDTH-1:0] res_data;
  status_e               res_status;

  logic                  ram_we;
  logic [SlotW-1:0]      ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  assign req   = req_e'(req_type_i);
  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  // Offset of the named slot from the head, modulo the depth.
  assign slot_x  = OffW'(slot_i);
  assign head_x  = OffW'(head_q);
  assign slot_ok = (slot_x < OffW'(DEPTH));
  assign offset  = (slot_x >= head_x) ? (slot_x - head_x) : (slot_x + OffW'(DEPTH) - head_x);
  assign live    = slot_ok && (offset < OffW'(count_q));
  // Entries behind the removed one; each moves one place toward the head.
  assign steps   = OffW'(count_q) - offset - 1'b1;

  assign stat_o.deq_wait   = (req == REQ_DEQ) && !empty;
  assign stat_o.shift_wait = (req == REQ_REM) && live && (steps != '0);
  assign stat_o.shift_last = (left_q == '0);

  // A shift's read pointer starts one entry ahead of its write pointer.
  assign ram_we    = (cmd_i.accept && (req == REQ_ENQ) && !full)
                  || (cmd_i.shift_run && wr_pend_q);
  assign ram_waddr = cmd_i.shift_run ? wr_ptr_q : tail_q;
  assign ram_wdata = cmd_i.shift_run ? ram_rdata : data_in_i;
  assign ram_raddr = cmd_i.shift_run ? rd_ptr_q : head_q;

  rqsr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    left_d     = left_q;
    wr_pend_d  = wr_pend_q;
    res_data   = '0;
    res_status = ST_OK;

    if (cmd_i.accept) begin
      unique case (req)
        REQ_ENQ: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            tail_d  = wrap_next(tail_q);
            count_d = count_q + 1'b1;
          end
        end
        REQ_DEQ: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end
        end
        REQ_CLR: begin
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end
        REQ_REM: begin
          if (!live) begin
            res_status = ST_NOSLOT;
          end else if (steps == '0) begin
            count_d = count_q - 1'b1;
            tail_d  = wrap_prev(tail_q);
          end else begin
            rd_ptr_d  = wrap_next(slot_i);
            wr_ptr_d  = slot_i;
            left_d    = steps[SlotW-1:0];
            wr_pend_d = 1'b0;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end

    if (cmd_i.deq_fin) begin
      res_data = ram_rdata;
      head_d   = wrap_next(head_q);
      count_d  = count_q - 1'b1;
    end

    if (cmd_i.shift_run) begin
      wr_pend_d = 1'b1;
      if (left_q != '0) begin
        rd_ptr_d = wrap_next(rd_ptr_q);
        left_d   = left_q - 1'b1;
      end
      if (wr_pend_q) begin
        wr_ptr_d = wrap_next(wr_ptr_q);
      end
      if (left_q == '0) begin
        count_d = count_q - 1'b1;
        tail_d  = wrap_prev(tail_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      left_q    <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      left_q    <= left_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    if (cmd_i.load_out) begin
      data_out_q <= res_data;
      status_q   <= res_status;
      cnt_out_q  <= count_d;
    end
  end

  assign data_out_o  = data_out_q;
  assign status_o    = status_q;
  assign count_out_o = cnt_out_q;

  // The tail must always sit count entries past the head.
  logic [OffW-1:0] tail_sum;
  logic [SlotW-1:0] tail_exp;
  assign tail_sum = head_x + OffW'(count_q);
  assign tail_exp = (tail_sum >= OffW'(DEPTH)) ? SlotW'(tail_sum - OffW'(DEPTH))
                                               : SlotW'(tail_sum);

  `RQSR_ASSERT_IMPL(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CntW'(DEPTH), "entry count beyond depth")
  `RQSR_ASSERT_IMPL(a_tail_track, clk_i, rst_ni, 1'b1, tail_q == tail_exp, "tail out of step with head and count")
  `RQSR_ASSERT_IMPL(a_shift_write, clk_i, rst_ni, cmd_i.shift_run && (left_q == '0), wr_pend_q, "last shift step has no data to write")

endmodule

`default_nettype wire

### rtl/ring_queue_with_slot_removal_core.sv
// Top level of the ring queue with slot removal.
// Depends on rqsr_pkg, rqsr_ctrl and rqsr_dpath (which holds rqsr_ram).
//
//   Channel  | Direction | Handshake              | Payload
//   ---------+-----------+------------------------+-------------------------------
//   request  | in        | in_valid_i / in_ready_o | req_type_i, data_in_i, slot_i
//   result   | out       | out_valid_o/out_ready_i | data_out_o, status_o, count_out_o
//
// Enqueue, clear, every refused request and a removal that moves no entries load
// their result as they are taken; a dequeue waits for the registered RAM read. A
// removal that moves entries shifts them toward the head, one entry per cycle
// through the RAM's single read and write ports. Reset clears head, tail and
// count; RAM contents are not cleared. A request is taken only while no long
// request runs and the result register is empty or being drained in that cycle.
`timescale 1ns / 1ps
`default_nettype none

module ring_queue_with_slot_removal_core
  import rqsr_pkg::*;
#(
  parameter int DEPTH      = DepthDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [DATA_WIDTH-1:0]      data_in_i,
  input  wire logic [$clog2(DEPTH)-1:0]   slot_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic [DATA_WIDTH-1:0]      data_out_o,
  output      logic [1:0]                 status_o,
  output      logic [$clog2(DEPTH+1)-1:0] count_out_o
);

  cmd_t  cmd;
  stat_t stat;

  rqsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rqsr_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_type_i  (req_type_i),
    .data_in_i   (data_in_i),
    .slot_i      (slot_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .count_out_o (count_out_o)
  );

endmodule

`default_nettype wire
